@@ rtl/sorted_list_insert_and_merge_top_defines.svh @@
// Assertion macros used by the back end of the sorted list RTL.
`ifndef SORTED_LIST_INSERT_AND_MERGE_TOP_DEFINES_SVH
`define SORTED_LIST_INSERT_AND_MERGE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SLI_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SLI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sli_pkg.sv @@
// Shared types, codes and constants of the sorted list insert and merge block.
`default_nettype none

package sli_pkg;

    localparam int LIST_DEPTH_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CAP_W           = 6;
    localparam int VALUE_W         = 32;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // Register selects (word address bit of the configuration port).
    localparam logic REG_SEL_CAP_A = 1'b0;
    localparam logic REG_SEL_CAP_B = 1'b1;

    // Input function codes.
    localparam logic [1:0] FUNC_INS_A = 2'd0;
    localparam logic [1:0] FUNC_INS_B = 2'd1;
    localparam logic [1:0] FUNC_MERGE = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    // Result kind codes.
    localparam logic [1:0] KIND_INS_ACK = 2'd0;
    localparam logic [1:0] KIND_ELEM    = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;
    localparam logic [1:0] KIND_CLR_ACK = 2'd3;

    typedef enum logic [1:0] {
        OP_INS_A,
        OP_INS_B,
        OP_MERGE,
        OP_CLEAR
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } back_state_t;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]                kind;
        logic                      accepted;
        logic signed [VALUE_W-1:0] element;
        logic                      last;
    } out_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    // Control from the back end to one list.
    typedef struct packed {
        logic ins_en;
        logic clr_en;
    } list_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/sorted_list_insert_and_merge_top.sv @@
// Path: an input passes the front-end holding register, command queue and result register.
// Back end: insert, clear and empty merge are each done when popped; a merge first pops
// and then emits one element per cycle from the single merge compare, held while the
// result register is stalled, and the front end keeps filling the queue meanwhile.
// Reset: synchronous active-low aresetn empties both lists, the queue and the
// result register, and sets both capacity registers to 32.
`default_nettype none

// Top level of the sorted list insert and merge block.
//
// The front end takes input transactions into a holding register and turns
// them into commands. A short queue decouples it from the back end, which
// owns the two sorted lists and the result register. Inserts go through a
// row of compare-and-shift cells in parallel; a merge walks both lists with
// one read pointer each and emits one result transaction per cycle unless stalled.
//
// Configuration is an APB-style port with two word registers: capacity of
// list A at byte address 0 and capacity of list B at byte address 4. Only
// the word address bit is decoded. pready is tied high.
module sorted_list_insert_and_merge_top #(
    parameter int LIST_DEPTH  = sli_pkg::LIST_DEPTH_DEF,
    parameter int QUEUE_DEPTH = sli_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input transactions.
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire sli_pkg::in_t                   s_payload,
    // Result transactions.
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output sli_pkg::out_t                       m_payload,
    // Configuration port.
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sli_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sli_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sli_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic [sli_pkg::CAP_W-1:0] cap_a_reg, cap_b_reg;
    logic                      cfg_wr;
    logic                      q_push, q_full, q_valid, q_pop;
    sli_pkg::cmd_t             q_in, q_out;

    // The register file sits here; capacities feed the back end directly.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_a_reg <= sli_pkg::CAP_RESET;
            cap_b_reg <= sli_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == sli_pkg::REG_SEL_CAP_A) begin
                cap_a_reg <= pwdata[sli_pkg::CAP_W-1:0];
            end else begin
                cap_b_reg <= pwdata[sli_pkg::CAP_W-1:0];
            end
        end
    end

    // Read data is unregistered, as the access phase allows.
    always_comb begin
        case (paddr[2])
            sli_pkg::REG_SEL_CAP_A:
                prdata = {{(sli_pkg::APB_DATA_W - sli_pkg::CAP_W){1'b0}}, cap_a_reg};
            sli_pkg::REG_SEL_CAP_B:
                prdata = {{(sli_pkg::APB_DATA_W - sli_pkg::CAP_W){1'b0}}, cap_b_reg};
            default:
                prdata = '0;
        endcase
    end

    // Front end: accept and classify.
    sli_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // Command queue between the two halves.
    sli_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop_data   (q_out),
        .pop_en     (q_pop)
    );

    // Back end: list storage, merge walk and result register.
    sli_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cap_a     (cap_a_reg),
        .cap_b     (cap_b_reg),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

@@ rtl/sli_fifo.sv @@
// Short command queue between the front end and the back end.
`default_nettype none

module sli_fifo #(
    parameter int DEPTH = sli_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    input  wire sli_pkg::cmd_t push_data,
    output logic               full,
    output logic               pop_valid,
    output sli_pkg::cmd_t      pop_data,
    input  wire logic          pop_en
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sli_pkg::cmd_t    entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_en && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sli_list.sv @@
// One sorted list held in a row of compare-and-shift cells.
`default_nettype none

module sli_list #(
    parameter int LIST_DEPTH = sli_pkg::LIST_DEPTH_DEF,
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1)
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire sli_pkg::list_ctrl_t                ctrl,
    input  wire logic signed [sli_pkg::VALUE_W-1:0] ins_value,
    input  wire logic [sli_pkg::CAP_W-1:0]          cap,
    input  wire logic [CNT_W-1:0]                   rd_idx,
    output logic signed [sli_pkg::VALUE_W-1:0]      rd_data,
    output logic [CNT_W-1:0]                        count,
    output logic                                    full
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic signed [sli_pkg::VALUE_W-1:0] cells_reg  [LIST_DEPTH];
    logic signed [sli_pkg::VALUE_W-1:0] cells_next [LIST_DEPTH];
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [LIST_DEPTH-1:0]              gt;
    logic [LIST_DEPTH-1:0]              shift_in;
    logic                               do_ins;

    assign count   = count_reg;
    assign rd_data = cells_reg[rd_idx[IDX_W-1:0]];
    assign full    = (sli_pkg::CAP_W'(count_reg) >= cap) ||
                     (count_reg == CNT_W'(LIST_DEPTH));
    assign do_ins  = ctrl.ins_en && !full;

    // A stored entry moves up when the new value sorts strictly below it,
    // so an equal value lands after the entries already there.
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            gt[i] = (CNT_W'(i) < count_reg) && (ins_value < cells_reg[i]);
        end
        shift_in[0] = 1'b0;
        for (int i = 1; i < LIST_DEPTH; i++) begin
            shift_in[i] = gt[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            cells_next[i] = cells_reg[i];
            if (do_ins) begin
                if (shift_in[i]) begin
                    cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                end else if (gt[i] || (CNT_W'(i) == count_reg)) begin
                    cells_next[i] = ins_value;
                end
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.clr_en) begin
            count_next = '0;
        end else if (do_ins) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            cells_reg[i] <= cells_next[i];
        end
    end

endmodule

`default_nettype wire

@@ rtl/sli_front.sv @@
// Front end: accepts input transactions and classifies them into commands.
`default_nettype none

module sli_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire sli_pkg::in_t s_payload,
    input  wire logic         q_full,
    output logic              q_push,
    output sli_pkg::cmd_t     q_data
);

    logic          hold_valid_reg, hold_valid_next;
    sli_pkg::cmd_t hold_cmd_reg;
    sli_pkg::cmd_t cmd_dec;
    logic          accept;

    assign q_push  = hold_valid_reg;
    assign q_data  = hold_cmd_reg;
    assign s_ready = !hold_valid_reg || !q_full;
    assign accept  = s_valid && s_ready;

    // Only inserts carry a value downstream.
    always_comb begin
        cmd_dec.value = '0;
        case (s_payload.func)
            sli_pkg::FUNC_INS_A: begin
                cmd_dec.op    = sli_pkg::OP_INS_A;
                cmd_dec.value = s_payload.value;
            end
            sli_pkg::FUNC_INS_B: begin
                cmd_dec.op    = sli_pkg::OP_INS_B;
                cmd_dec.value = s_payload.value;
            end
            sli_pkg::FUNC_MERGE: cmd_dec.op = sli_pkg::OP_MERGE;
            sli_pkg::FUNC_CLEAR: cmd_dec.op = sli_pkg::OP_CLEAR;
            default:             cmd_dec.op = sli_pkg::OP_CLEAR;
        endcase
    end

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
        end else if (!q_full) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_cmd_reg <= cmd_dec;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sli_back.sv @@
// Back end: executes commands on both lists and drives the result register.
`default_nettype none
`include "sorted_list_insert_and_merge_top_defines.svh"

module sli_back #(
    parameter int LIST_DEPTH = sli_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [sli_pkg::CAP_W-1:0] cap_a,
    input  wire logic [sli_pkg::CAP_W-1:0] cap_b,
    input  wire logic                      q_valid,
    input  wire sli_pkg::cmd_t             q_data,
    output logic                           q_pop,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output sli_pkg::out_t                  m_payload
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    sli_pkg::back_state_t               state_reg, state_next;
    logic [CNT_W-1:0]                   ia_reg, ia_next, ib_reg, ib_next;
    logic                               m_valid_reg;
    sli_pkg::out_t                      m_payload_reg;
    sli_pkg::out_t                      res;
    sli_pkg::list_ctrl_t                ctrl_a, ctrl_b;
    logic signed [sli_pkg::VALUE_W-1:0] a_data, b_data;
    logic [CNT_W-1:0]                   na, nb;
    logic                               full_a, full_b;
    logic [CNT_W:0]                     total, done_cnt;
    logic                               a_left, b_left, take_a, is_last;
    logic                               can_emit, emit;

    sli_list #(.LIST_DEPTH(LIST_DEPTH)) u_list_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl_a),
        .ins_value (q_data.value),
        .cap       (cap_a),
        .rd_idx    (ia_reg),
        .rd_data   (a_data),
        .count     (na),
        .full      (full_a)
    );

    sli_list #(.LIST_DEPTH(LIST_DEPTH)) u_list_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl_b),
        .ins_value (q_data.value),
        .cap       (cap_b),
        .rd_idx    (ib_reg),
        .rd_data   (b_data),
        .count     (nb),
        .full      (full_b)
    );

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;
    assign can_emit  = !m_valid_reg || m_ready;

    // Merge head selection; on a tie the B element goes first.
    assign total    = {1'b0, na} + {1'b0, nb};
    assign done_cnt = {1'b0, ia_reg} + {1'b0, ib_reg};
    assign a_left   = (ia_reg < na);
    assign b_left   = (ib_reg < nb);
    assign take_a   = a_left && (!b_left || (a_data < b_data));
    assign is_last  = ((done_cnt + 1'b1) == total);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sli_pkg::ST_IDLE: begin
                if (q_valid && can_emit && (q_data.op == sli_pkg::OP_MERGE) &&
                    (total != '0)) begin
                    state_next = sli_pkg::ST_MERGE;
                end
            end
            sli_pkg::ST_MERGE: begin
                if (can_emit && is_last) begin
                    state_next = sli_pkg::ST_IDLE;
                end
            end
            default: state_next = sli_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop   = 1'b0;
        ctrl_a  = '0;
        ctrl_b  = '0;
        emit    = 1'b0;
        res     = '0;
        ia_next = ia_reg;
        ib_next = ib_reg;
        case (state_reg)
            sli_pkg::ST_IDLE: begin
                if (q_valid && can_emit) begin
                    q_pop    = 1'b1;
                    emit     = 1'b1;
                    res.last = 1'b1;
                    case (q_data.op)
                        sli_pkg::OP_INS_A: begin
                            ctrl_a.ins_en = 1'b1;
                            res.kind      = sli_pkg::KIND_INS_ACK;
                            res.accepted  = !full_a;
                        end
                        sli_pkg::OP_INS_B: begin
                            ctrl_b.ins_en = 1'b1;
                            res.kind      = sli_pkg::KIND_INS_ACK;
                            res.accepted  = !full_b;
                        end
                        sli_pkg::OP_MERGE: begin
                            if (total == '0) begin
                                res.kind = sli_pkg::KIND_EMPTY;
                            end else begin
                                emit    = 1'b0;
                                ia_next = '0;
                                ib_next = '0;
                            end
                        end
                        sli_pkg::OP_CLEAR: begin
                            ctrl_a.clr_en = 1'b1;
                            ctrl_b.clr_en = 1'b1;
                            res.kind      = sli_pkg::KIND_CLR_ACK;
                        end
                        default: emit = 1'b0;
                    endcase
                end
            end
            sli_pkg::ST_MERGE: begin
                if (can_emit) begin
                    emit        = 1'b1;
                    res.kind    = sli_pkg::KIND_ELEM;
                    res.element = take_a ? a_data : b_data;
                    res.last    = is_last;
                    if (take_a) begin
                        ia_next = ia_reg + 1'b1;
                    end else begin
                        ib_next = ib_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sli_pkg::ST_IDLE;
            ia_reg      <= '0;
            ib_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ia_reg    <= ia_next;
            ib_reg    <= ib_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_payload_reg <= res;
        end
    end

    `SLI_ASSERT_IMPLY(a_merge_idx_range, state_reg == sli_pkg::ST_MERGE,
        (ia_reg <= na) && (ib_reg <= nb) && (a_left || b_left),
        "merge pointers ran past the stored elements")
    `SLI_ASSERT_NEXT(a_merge_last_ends, (state_reg == sli_pkg::ST_MERGE) && emit && is_last,
        state_reg == sli_pkg::ST_IDLE, "merge did not end after its last element")
    `SLI_ASSERT_IMPLY(a_merge_blocks_cmds, state_reg == sli_pkg::ST_MERGE,
        !q_pop && !ctrl_a.ins_en && !ctrl_b.ins_en && !ctrl_a.clr_en,
        "command executed while a merge was running")
    `SLI_ASSERT_IMPLY(a_non_elem_zero,
        m_valid_reg && (m_payload_reg.kind != sli_pkg::KIND_ELEM),
        m_payload_reg.element == '0, "non-element result carries a value")

endmodule

`default_nettype wire

@@ tb/tb_sorted_list_insert_and_merge_top.sv @@
// Self-checking testbench of the sorted list insert and merge block with a built-in list predictor.
`default_nettype none

module tb_sorted_list_insert_and_merge_top;

    localparam int LIST_DEPTH   = sli_pkg::LIST_DEPTH_DEF;
    localparam int LIST_A       = 0;
    localparam int LIST_B       = 1;
    localparam int IDLE_LIMIT   = 4000;
    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE       = 6;

    // Byte addresses of the two capacity registers.
    localparam logic [sli_pkg::APB_ADDR_W-1:0] ADDR_CAP_A = {sli_pkg::REG_SEL_CAP_A, 2'b00};
    localparam logic [sli_pkg::APB_ADDR_W-1:0] ADDR_CAP_B = {sli_pkg::REG_SEL_CAP_B, 2'b00};

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    sli_pkg::in_t                   s_payload = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    sli_pkg::out_t                  m_payload;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [sli_pkg::APB_ADDR_W-1:0] paddr     = '0;
    logic [sli_pkg::APB_DATA_W-1:0] pwdata    = '0;
    logic [sli_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    sorted_list_insert_and_merge_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predicted contents of both lists and the capacity registers.
    logic signed [sli_pkg::VALUE_W-1:0] list_vals [2][LIST_DEPTH];
    logic [sli_pkg::CAP_W-1:0]          list_len  [2] = '{default: '0};
    logic [sli_pkg::CAP_W-1:0]          list_cap  [2] = '{default: sli_pkg::CAP_RESET};

    sli_pkg::in_t  queued_cmds[$];
    sli_pkg::out_t owed_results[$];

    int  mismatch_count = 0;
    int  idle_cycles    = 0;
    int  tx_gap         = 0;
    int  rx_gap         = 0;
    bit  no_idle        = 1'b0;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Sorted insert that places a value after any equal ones already stored.
    function automatic bit insert_sorted(int l, logic signed [sli_pkg::VALUE_W-1:0] v);
        int lim;
        int i;
        lim = (list_cap[l] < LIST_DEPTH) ? list_cap[l] : LIST_DEPTH;
        i = list_len[l];
        if (i >= lim) return 1'b0;
        while (i > 0 && v < list_vals[l][i-1]) begin
            list_vals[l][i] = list_vals[l][i-1];
            i--;
        end
        list_vals[l][i] = v;
        list_len[l] = list_len[l] + 1'b1;
        return 1'b1;
    endfunction

    // Works out the result transactions that one accepted command owes.
    function automatic void track_list_cmd(sli_pkg::in_t cmd);
        int  ia;
        int  ib;
        int  total;
        bit  ok;
        logic signed [sli_pkg::VALUE_W-1:0] e;
        ia = 0;
        ib = 0;
        case (cmd.func)
            sli_pkg::FUNC_INS_A, sli_pkg::FUNC_INS_B: begin
                ok = insert_sorted((cmd.func == sli_pkg::FUNC_INS_A) ? LIST_A : LIST_B,
                                   cmd.value);
                owed_results.push_back(sli_pkg::out_t'{kind: sli_pkg::KIND_INS_ACK,
                                                       accepted: ok,
                                                       element: '0, last: 1'b1});
            end
            sli_pkg::FUNC_CLEAR: begin
                list_len[LIST_A] = '0;
                list_len[LIST_B] = '0;
                owed_results.push_back(sli_pkg::out_t'{kind: sli_pkg::KIND_CLR_ACK,
                                                       accepted: 1'b0,
                                                       element: '0, last: 1'b1});
            end
            default: begin
                total = list_len[LIST_A] + list_len[LIST_B];
                if (total == 0) begin
                    owed_results.push_back(sli_pkg::out_t'{kind: sli_pkg::KIND_EMPTY,
                                                           accepted: 1'b0,
                                                           element: '0, last: 1'b1});
                end else begin
                    // On a tie the B element goes out first, so A wins only when strictly less.
                    for (int k = 0; k < total; k++) begin
                        if (ia < list_len[LIST_A] && (ib >= list_len[LIST_B] ||
                                list_vals[LIST_A][ia] < list_vals[LIST_B][ib])) begin
                            e = list_vals[LIST_A][ia];
                            ia++;
                        end else begin
                            e = list_vals[LIST_B][ib];
                            ib++;
                        end
                        owed_results.push_back(sli_pkg::out_t'{kind: sli_pkg::KIND_ELEM,
                                                               accepted: 1'b0, element: e,
                                                               last: (k + 1 == total)});
                    end
                end
            end
        endcase
    endfunction

    // Driver: presents queued commands, with random gaps between transactions.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                track_list_cmd(s_payload);
                tx_gap = pick_gap();
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (queued_cmds.size() > 0) begin
                    s_payload <= queued_cmds.pop_front();
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction against the oldest owed one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected result: kind %0d accepted %0d element %0d last %0d",
                             m_payload.kind, m_payload.accepted, m_payload.element,
                             m_payload.last);
                mismatch_count++;
            end else begin
                sli_pkg::out_t want;
                want = owed_results.pop_front();
                if (m_payload.kind !== want.kind || m_payload.accepted !== want.accepted ||
                        m_payload.element !== want.element || m_payload.last !== want.last) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("mismatch: expected kind %0d acc %0d elem %0d last %0d, %s",
                                 want.kind, want.accepted, want.element, want.last,
                                 $sformatf("got kind %0d acc %0d elem %0d last %0d",
                                           m_payload.kind, m_payload.accepted,
                                           m_payload.element, m_payload.last));
                    mismatch_count++;
                end
            end
            rx_gap = pick_gap();
        end else if (rx_gap > 0) begin
            rx_gap--;
        end
        m_ready <= (rx_gap == 0);
    end

    // Watchdog: ends the run when no transaction of any kind moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (psel && penable && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic signed [sli_pkg::VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            1, 2: return $signed($urandom_range(0, 8)) - 32'sd4;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] rand_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 42) return sli_pkg::FUNC_INS_A;
        if (r < 84) return sli_pkg::FUNC_INS_B;
        if (r < 95) return sli_pkg::FUNC_MERGE;
        return sli_pkg::FUNC_CLEAR;
    endfunction

    function automatic logic [sli_pkg::CAP_W-1:0] rand_cap();
        case ($urandom_range(0, 5))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd32;
            3: return 6'd63;
            default: return sli_pkg::CAP_W'($urandom_range(1, 32));
        endcase
    endfunction

    task automatic put_cmd(logic [1:0] f, logic signed [sli_pkg::VALUE_W-1:0] v);
        queued_cmds.push_back(sli_pkg::in_t'{func: f, value: v});
    endtask

    // Waits until every command went in and every owed result came out, then a bit longer.
    // The check runs between edges so that it sees the state after the driver and monitor.
    task automatic wait_drained();
        do @(negedge aclk);
        while (queued_cmds.size() != 0 || s_valid || owed_results.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Setup and access cycles; the register takes the value at the access edge.
    task automatic write_capacity(int l, logic [sli_pkg::CAP_W-1:0] cap);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (l == LIST_A) ? ADDR_CAP_A : ADDR_CAP_B;
        pwdata  <= {{(sli_pkg::APB_DATA_W-sli_pkg::CAP_W){1'b0}}, cap};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        list_cap[l] = cap;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_phase(int n_items, bit hold_midway);
        write_capacity(LIST_A, rand_cap());
        write_capacity(LIST_B, rand_cap());
        // Skipping the opening clear now and then keeps old contents under new capacities.
        if ($urandom_range(0, 9) < 6) put_cmd(sli_pkg::FUNC_CLEAR, rand_value());
        for (int i = 0; i < n_items; i++) begin
            if (hold_midway && i == n_items / 2) wait_drained();
            put_cmd(rand_func(), rand_value());
        end
        put_cmd(sli_pkg::FUNC_MERGE, rand_value());
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: extremes, ties within and across lists, empty merges.
        write_capacity(LIST_A, 6'd32);
        write_capacity(LIST_B, 6'd32);
        put_cmd(sli_pkg::FUNC_MERGE, 32'sh0);
        put_cmd(sli_pkg::FUNC_CLEAR, -32'sd1);
        put_cmd(sli_pkg::FUNC_INS_A, 32'sh7FFF_FFFF);
        put_cmd(sli_pkg::FUNC_INS_A, 32'sh8000_0000);
        put_cmd(sli_pkg::FUNC_INS_A, 32'sh0);
        put_cmd(sli_pkg::FUNC_INS_A, 32'sh0);
        put_cmd(sli_pkg::FUNC_INS_A, -32'sd1);
        put_cmd(sli_pkg::FUNC_INS_B, 32'sh0);
        put_cmd(sli_pkg::FUNC_INS_B, 32'sh8000_0000);
        put_cmd(sli_pkg::FUNC_INS_B, 32'sh7FFF_FFFF);
        put_cmd(sli_pkg::FUNC_INS_B, 32'sd5);
        put_cmd(sli_pkg::FUNC_INS_B, -32'sd1);
        put_cmd(sli_pkg::FUNC_MERGE, 32'sh7FFF_FFFF);
        put_cmd(sli_pkg::FUNC_INS_A, 32'sh5555_5555);
        put_cmd(sli_pkg::FUNC_INS_B, 32'shAAAA_AAAA);
        put_cmd(sli_pkg::FUNC_MERGE, 32'sh8000_0000);
        put_cmd(sli_pkg::FUNC_CLEAR, 32'sh0);
        put_cmd(sli_pkg::FUNC_MERGE, 32'sh0);
        put_cmd(sli_pkg::FUNC_INS_B, 32'sd7);
        put_cmd(sli_pkg::FUNC_MERGE, 32'sh0);
        put_cmd(sli_pkg::FUNC_CLEAR, 32'sh0);
        put_cmd(sli_pkg::FUNC_INS_A, 32'sd3);
        put_cmd(sli_pkg::FUNC_MERGE, 32'sh0);
        wait_drained();

        // Capacity one on A and zero on B: second A insert and every B insert are dropped.
        write_capacity(LIST_A, 6'd1);
        write_capacity(LIST_B, 6'd0);
        put_cmd(sli_pkg::FUNC_CLEAR, 32'sh0);
        put_cmd(sli_pkg::FUNC_INS_A, 32'sd10);
        put_cmd(sli_pkg::FUNC_INS_A, 32'sd20);
        put_cmd(sli_pkg::FUNC_INS_B, 32'sd1);
        put_cmd(sli_pkg::FUNC_MERGE, 32'sh0);
        wait_drained();

        // Capacity lowered below the count: stored elements stay and still merge.
        write_capacity(LIST_A, 6'd63);
        for (int i = 0; i < 4; i++) put_cmd(sli_pkg::FUNC_INS_A, rand_value());
        wait_drained();
        write_capacity(LIST_A, 6'd2);
        put_cmd(sli_pkg::FUNC_INS_A, 32'sd99);
        put_cmd(sli_pkg::FUNC_MERGE, 32'sh0);
        put_cmd(sli_pkg::FUNC_CLEAR, 32'sh0);
        put_cmd(sli_pkg::FUNC_INS_A, 32'sd2);
        put_cmd(sli_pkg::FUNC_INS_A, 32'sd1);
        put_cmd(sli_pkg::FUNC_INS_A, 32'sd0);
        put_cmd(sli_pkg::FUNC_MERGE, 32'sh0);
        wait_drained();

        // Both lists filled past their depth, capacity above depth on A: the longest merge.
        write_capacity(LIST_A, 6'd63);
        write_capacity(LIST_B, 6'd32);
        put_cmd(sli_pkg::FUNC_CLEAR, 32'sh0);
        for (int i = 0; i < 34; i++) put_cmd(sli_pkg::FUNC_INS_A, rand_value());
        for (int i = 0; i < 33; i++) put_cmd(sli_pkg::FUNC_INS_B, rand_value());
        put_cmd(sli_pkg::FUNC_MERGE, 32'sh0);
        put_cmd(sli_pkg::FUNC_MERGE, 32'sh0);
        wait_drained();

        // Random phases; one runs without idling and one drains the block midway.
        for (int p = 0; p < 10; p++) begin
            no_idle = (p == 3);
            random_phase(30, p == 5);
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
